// ===== hw/rtl/rppr_pkg.sv =====
// ----------------------------------------------------------------------------
// rppr_pkg: shared types, constants and helpers for the rotary pair rotator
// Word formats passed between the front end, the queue and the back end,
// the Taylor-series divisor table with its reciprocals, and the small
// arithmetic helpers used by more than one stage.
// ----------------------------------------------------------------------------
package rppr_pkg;

    // Default build values
    localparam int RPPR_HEAD_SIZE   = 128;
    localparam int RPPR_FREQ_BASE   = 10000;
    localparam int RPPR_QUEUE_DEPTH = 4;

    // Field widths
    localparam int POS_W   = 16;
    localparam int PAIR_W  = 6;
    localparam int VAL_W   = 16;
    localparam int PHASE_W = 32;
    localparam int TRIG_W  = 32;
    localparam int RES_W   = 19;

    localparam int FREQ_ROM_SIZE = 2 ** PAIR_W;

    // Fixed-point constants
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [30:0] QUARTER_TURN   = 31'h4000_0000;
    localparam logic [29:0] EIGHTH_TURN    = 30'h2000_0000;
    localparam logic [48:0] ROUND_HALF     = 49'h0_0000_2000_0000;

    // Quadrant codes (top two phase bits)
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Horner steps: divisors, reciprocal shifts (30 + ceil(log2 d)), reciprocals
    localparam int HSTEPS = 4;
    localparam int unsigned SIN_DIV [HSTEPS] = '{72, 42, 20, 6};
    localparam int unsigned COS_DIV [HSTEPS] = '{56, 30, 12, 2};
    localparam int unsigned SIN_SHF [HSTEPS] = '{37, 36, 35, 33};
    localparam int unsigned COS_SHF [HSTEPS] = '{36, 35, 34, 31};
    localparam logic [31:0] SIN_REC [HSTEPS] = '{
        32'((64'd1 << 37) / 64'd72), 32'((64'd1 << 36) / 64'd42),
        32'((64'd1 << 35) / 64'd20), 32'((64'd1 << 33) / 64'd6)};
    localparam logic [31:0] COS_REC [HSTEPS] = '{
        32'((64'd1 << 36) / 64'd56), 32'((64'd1 << 35) / 64'd30),
        32'((64'd1 << 34) / 64'd12), 32'((64'd1 << 31) / 64'd2)};

    // Queue word: phase plus the two values
    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] second_value;
    } rppr_word_t;

    // Values and fold info carried along the back end
    typedef struct packed {
        logic [1:0]              quad;
        logic                    swap;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] second_value;
    } rppr_side_t;

    // Queue status toward the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } rppr_qstat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    clip;
    } rppr_sat_t;

    // Truncating integer square root (elaboration-time use only)
    function automatic logic [63:0] isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Finish one Horner step: floor(v / d) by reciprocal with one correction,
    // then one minus the quotient
    function automatic logic [30:0] horner_finish(
        input logic [61:0] prod,
        input logic [29:0] v,
        input int unsigned shf,
        input int unsigned dv
    );
        logic [61:0] q_full;
        logic [29:0] q0;
        logic [29:0] back;
        logic [29:0] rem;
        logic [29:0] q;
        q_full = prod >> shf;
        q0     = q_full[29:0];
        back   = 30'(q0 * 30'(dv));
        rem    = v - back;
        q      = (rem >= 30'(dv)) ? q0 + 30'd1 : q0;
        return Q30_ONE - {1'b0, q};
    endfunction

    // Clip a rounded result to 16 bits
    function automatic rppr_sat_t sat16(input logic signed [RES_W-1:0] r);
        rppr_sat_t s;
        if (r > 19'sd32767) begin
            s.value = 16'sh7FFF;
            s.clip  = 1'b1;
        end else if (r < -19'sd32768) begin
            s.value = 16'sh8000;
            s.clip  = 1'b1;
        end else begin
            s.value = r[VAL_W-1:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/rppr_front.sv =====
// ----------------------------------------------------------------------------
// rppr_front: input stage, frequency lookup and phase
// Takes words from the input channel, looks up the turn frequency of the
// pair in a build-time table, forms the phase and pushes it to the queue.
// ----------------------------------------------------------------------------
module rppr_front
    import rppr_pkg::*;
#(
    parameter int HEAD_SIZE = RPPR_HEAD_SIZE,
    parameter int FREQ_BASE = RPPR_FREQ_BASE
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [POS_W-1:0]        position,
    input  logic [PAIR_W-1:0]       pair_index,
    input  logic signed [VAL_W-1:0] first_value,
    input  logic signed [VAL_W-1:0] second_value,
    input  rppr_qstat_t             qstat,
    output logic                    push,
    output rppr_word_t              push_word
);

    // Turn frequency FREQ_BASE^(-2*idx/HEAD_SIZE) as a Q0.32 fraction of a turn
    function automatic logic [31:0] turn_freq(input int unsigned idx);
        logic [63:0] base;
        logic [63:0] m;
        logic [63:0] lg;
        logic [63:0] e;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] prod;
        int n;
        base = 64'(FREQ_BASE);
        if (base == 0) base = 64'd1;
        n = 0;
        while (n < 63 && (base >> (n + 1)) != 0) n++;
        m  = (n <= 31) ? (base << (31 - n)) : (base >> (n - 31));
        lg = '0;
        for (int j = 1; j <= 32; j++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m  = m >> 1;
                lg = lg | (64'd1 << (32 - j));
            end
        end
        lg = lg | (64'(n) << 32);
        e  = (lg * 64'd2 * 64'(idx)) / HEAD_SIZE;
        k  = e >> 32;
        f  = e & 64'hFFFF_FFFF;
        r  = 64'd1 << 32;
        c  = 64'd1 << 31;
        for (int j = 1; j <= 32; j++) begin
            c = isqrt(c << 32);
            if (((f >> (32 - j)) & 64'd1) != 0) r = (r * c) >> 32;
        end
        prod = r * INV_TWO_PI_Q32;
        if (k >= 32) return 32'd0;
        return 32'(prod >> (32 + k));
    endfunction

    // Frequency table, one entry per pair index
    logic [31:0] freq_rom [FREQ_ROM_SIZE];

    for (genvar i = 0; i < FREQ_ROM_SIZE; i++)
    begin : g_rom
        localparam logic [31:0] FreqVal = turn_freq(i);
        assign freq_rom[i] = FreqVal;
    end

    logic                    s1_valid_reg;
    logic [POS_W-1:0]        s1_pos_reg;
    logic [31:0]             s1_freq_reg;
    logic signed [VAL_W-1:0] s1_first_reg;
    logic signed [VAL_W-1:0] s1_second_reg;
    logic                    s2_valid_reg;
    rppr_word_t              s2_word_reg;
    logic                    s1_ready;
    logic                    s2_ready;
    logic                    accept;
    logic [47:0]             phase_prod;

    // Handshake: each stage moves when the one after it has room
    assign s2_ready   = !s2_valid_reg || !qstat.full;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_stall = !s1_ready;
    assign accept     = item_valid && s1_ready;
    assign push       = s2_valid_reg && !qstat.full;
    assign push_word  = s2_word_reg;

    // Low 32 bits of position times frequency
    assign phase_prod = s1_pos_reg * s1_freq_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg    <= position;
            s1_freq_reg   <= freq_rom[pair_index];
            s1_first_reg  <= first_value;
            s1_second_reg <= second_value;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_word_reg.phase        <= phase_prod[PHASE_W-1:0];
            s2_word_reg.first_value  <= s1_first_reg;
            s2_word_reg.second_value <= s1_second_reg;
        end
    end

    // Input is held off only while both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && s2_valid_reg))
        else $error("input stalled with a free front stage");

endmodule

// ===== hw/rtl/rppr_queue.sv =====
// ----------------------------------------------------------------------------
// rppr_queue: word queue between the front and back ends
// Small first-in first-out store; the head is visible combinationally.
// ----------------------------------------------------------------------------
module rppr_queue
    import rppr_pkg::*;
#(
    parameter int DEPTH = RPPR_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rppr_word_t  wdata,
    input  logic        pop,
    output rppr_word_t  rdata,
    output rppr_qstat_t stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rppr_word_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from an empty queue");

    a_head_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && stat.empty && !pop) |=> (rdata == $past(wdata)))
        else $error("word pushed into an empty queue is not at the head");

endmodule

// ===== hw/rtl/rppr_sincos.sv =====
// ----------------------------------------------------------------------------
// rppr_sincos: sine and cosine of the phase
// Folds the phase into the first eighth turn, converts it to radians and
// evaluates the sine and cosine series in Horner form, then unfolds by
// octant and quadrant. All stages advance together on the enable.
// ----------------------------------------------------------------------------
module rppr_sincos
    import rppr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  rppr_word_t               in_word,
    output logic                     out_valid,
    output rppr_side_t               out_side,
    output logic signed [TRIG_W-1:0] out_sin,
    output logic signed [TRIG_W-1:0] out_cos
);

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        rppr_side_t  side;
    } sc_carry_t;

    // Fold stage
    logic [29:0] t_in;
    logic        swap_in;
    logic [30:0] u_diff;
    logic        fold_valid_reg;
    logic [29:0] u_reg;
    rppr_side_t  fold_side_reg;

    assign t_in    = in_word.phase[29:0];
    assign swap_in = (t_in > EIGHTH_TURN);
    assign u_diff  = QUARTER_TURN - {1'b0, t_in};

    // Radian and square stages
    logic [62:0] x_prod;
    logic        x_valid_reg;
    logic [29:0] x_reg;
    rppr_side_t  x_side_reg;
    logic [59:0] x2_prod;
    logic        x2_valid_reg;
    sc_carry_t   x2_carry_reg;

    assign x_prod  = u_reg * TWO_PI_Q30;
    assign x2_prod = x_reg * x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            x_valid_reg    <= 1'b0;
            x2_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            fold_valid_reg <= in_valid;
            x_valid_reg    <= fold_valid_reg;
            x2_valid_reg   <= x_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg                      <= swap_in ? u_diff[29:0] : t_in;
            fold_side_reg.quad         <= in_word.phase[31:30];
            fold_side_reg.swap         <= swap_in;
            fold_side_reg.first_value  <= in_word.first_value;
            fold_side_reg.second_value <= in_word.second_value;
            x_reg                      <= x_prod[61:32];
            x_side_reg                 <= fold_side_reg;
            x2_carry_reg.x             <= x_reg;
            x2_carry_reg.x2            <= x2_prod[59:30];
            x2_carry_reg.side          <= x_side_reg;
        end
    end

    // Horner chain: three stages per step (product, reciprocal, finish)
    logic        h_valid [HSTEPS+1];
    sc_carry_t   h_carry [HSTEPS+1];
    logic [30:0] h_ts    [HSTEPS+1];
    logic [30:0] h_tc    [HSTEPS+1];

    assign h_valid[0] = x2_valid_reg;
    assign h_carry[0] = x2_carry_reg;
    assign h_ts[0]    = Q30_ONE;
    assign h_tc[0]    = Q30_ONE;

    for (genvar g = 0; g < HSTEPS; g++)
    begin : g_step
        logic        a_valid_reg;
        logic        b_valid_reg;
        logic        c_valid_reg;
        sc_carry_t   a_carry_reg;
        sc_carry_t   b_carry_reg;
        sc_carry_t   c_carry_reg;
        logic [29:0] a_vs_reg;
        logic [29:0] a_vc_reg;
        logic [29:0] b_vs_reg;
        logic [29:0] b_vc_reg;
        logic [61:0] b_ps_reg;
        logic [61:0] b_pc_reg;
        logic [30:0] c_ts_reg;
        logic [30:0] c_tc_reg;
        logic [60:0] prod_s;
        logic [60:0] prod_c;
        logic [61:0] rec_s;
        logic [61:0] rec_c;

        assign prod_s = h_carry[g].x2 * h_ts[g];
        assign prod_c = h_carry[g].x2 * h_tc[g];
        assign rec_s  = a_vs_reg * SIN_REC[g];
        assign rec_c  = a_vc_reg * COS_REC[g];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_valid_reg <= 1'b0;
                b_valid_reg <= 1'b0;
                c_valid_reg <= 1'b0;
            end
            else if (en)
            begin
                a_valid_reg <= h_valid[g];
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_vs_reg    <= prod_s[59:30];
                a_vc_reg    <= prod_c[59:30];
                a_carry_reg <= h_carry[g];
                b_vs_reg    <= a_vs_reg;
                b_vc_reg    <= a_vc_reg;
                b_ps_reg    <= rec_s;
                b_pc_reg    <= rec_c;
                b_carry_reg <= a_carry_reg;
                c_ts_reg    <= horner_finish(b_ps_reg, b_vs_reg, SIN_SHF[g], SIN_DIV[g]);
                c_tc_reg    <= horner_finish(b_pc_reg, b_vc_reg, COS_SHF[g], COS_DIV[g]);
                c_carry_reg <= b_carry_reg;
            end
        end

        assign h_valid[g+1] = c_valid_reg;
        assign h_carry[g+1] = c_carry_reg;
        assign h_ts[g+1]    = c_ts_reg;
        assign h_tc[g+1]    = c_tc_reg;
    end

    // Sine from x * series, cosine from its series
    logic [60:0] sv_prod;
    logic        e1_valid_reg;
    logic [29:0] sv_reg;
    logic [30:0] cv_reg;
    rppr_side_t  e1_side_reg;

    assign sv_prod = h_carry[HSTEPS].x * h_ts[HSTEPS];

    // Octant swap and quadrant signs
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] c0;
    logic signed [TRIG_W-1:0] sin_next;
    logic signed [TRIG_W-1:0] cos_next;
    logic                     e2_valid_reg;
    rppr_side_t               e2_side_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    always_comb
    begin
        if (e1_side_reg.swap)
        begin
            s0 = {1'b0, cv_reg};
            c0 = {2'b0, sv_reg};
        end
        else
        begin
            s0 = {2'b0, sv_reg};
            c0 = {1'b0, cv_reg};
        end
        unique case (e1_side_reg.quad)
            QUAD_FIRST:
            begin
                sin_next = s0;
                cos_next = c0;
            end
            QUAD_SECOND:
            begin
                sin_next = c0;
                cos_next = -s0;
            end
            QUAD_THIRD:
            begin
                sin_next = -s0;
                cos_next = -c0;
            end
            QUAD_FOURTH:
            begin
                sin_next = -c0;
                cos_next = s0;
            end
            default:
            begin
                sin_next = s0;
                cos_next = c0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg <= h_valid[HSTEPS];
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg      <= sv_prod[59:30];
            cv_reg      <= h_tc[HSTEPS];
            e1_side_reg <= h_carry[HSTEPS].side;
            sin_reg     <= sin_next;
            cos_reg     <= cos_next;
            e2_side_reg <= e1_side_reg;
        end
    end

    assign out_valid = e2_valid_reg;
    assign out_side  = e2_side_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;

endmodule

// ===== hw/rtl/rppr_rotate.sv =====
// ----------------------------------------------------------------------------
// rppr_rotate: plane rotation, rounding and saturation
// Four products, then the two sums rounded to Q4.12 and clipped into the
// result register that drives the output channel.
// ----------------------------------------------------------------------------
module rppr_rotate
    import rppr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  rppr_side_t               in_side,
    input  logic signed [TRIG_W-1:0] in_sin,
    input  logic signed [TRIG_W-1:0] in_cos,
    output logic                     result_valid,
    output logic signed [VAL_W-1:0]  first_rotated,
    output logic signed [VAL_W-1:0]  second_rotated,
    output logic                     saturated
);

    // Product stage
    logic signed [47:0] p_fc;
    logic signed [47:0] p_ss;
    logic signed [47:0] p_fs;
    logic signed [47:0] p_sc;
    logic               p_valid_reg;
    logic signed [47:0] p_fc_reg;
    logic signed [47:0] p_ss_reg;
    logic signed [47:0] p_fs_reg;
    logic signed [47:0] p_sc_reg;

    assign p_fc = in_side.first_value * in_cos;
    assign p_ss = in_side.second_value * in_sin;
    assign p_fs = in_side.first_value * in_sin;
    assign p_sc = in_side.second_value * in_cos;

    // Sum, round half up at bit 30, clip
    logic [48:0] acc0;
    logic [48:0] acc1;
    logic [48:0] rnd0;
    logic [48:0] rnd1;
    rppr_sat_t   sat0;
    rppr_sat_t   sat1;

    assign acc0 = {p_fc_reg[47], p_fc_reg} - {p_ss_reg[47], p_ss_reg};
    assign acc1 = {p_fs_reg[47], p_fs_reg} + {p_sc_reg[47], p_sc_reg};
    assign rnd0 = acc0 + ROUND_HALF;
    assign rnd1 = acc1 + ROUND_HALF;
    assign sat0 = sat16($signed(rnd0[48:30]));
    assign sat1 = sat16($signed(rnd1[48:30]));

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] first_reg;
    logic signed [VAL_W-1:0] second_reg;
    logic                    sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg   <= in_valid;
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_fc_reg   <= p_fc;
            p_ss_reg   <= p_ss;
            p_fs_reg   <= p_fs;
            p_sc_reg   <= p_sc;
            first_reg  <= sat0.value;
            second_reg <= sat1.value;
            sat_reg    <= sat0.clip | sat1.clip;
        end
    end

    assign result_valid   = out_valid_reg;
    assign first_rotated  = first_reg;
    assign second_rotated = second_reg;
    assign saturated      = sat_reg;

endmodule

// ===== hw/rtl/rotary_position_pair_rotator.sv =====
// ----------------------------------------------------------------------------
// rotary_position_pair_rotator: rotary position rotation of one value pair
// Top level: front end, queue, sine/cosine back end and rotation.
// ----------------------------------------------------------------------------
// Takes one word per cycle when item_stall is low (position, pair index and
// a Q4.12 pair) and returns the pair rotated by the angle position *
// FREQ_BASE^(-2*i/HEAD_SIZE), rounded and clipped to 16 bits, with a flag
// when clipping happened. Words are accepted back to back at one per cycle
// while no stall holds them; a word passes two front stages (table lookup,
// phase multiply), the queue, and 19 back-end stages, most of them the
// twelve multiply stages of the Horner series evaluation. The back end moves
// as one pipeline and holds only while a result waits under result_stall;
// the queue (QUEUE_DEPTH words) and the two front stages keep taking words
// in that time until they fill. The frequency table is built from HEAD_SIZE
// and FREQ_BASE at elaboration; a pair index past HEAD_SIZE/2 uses the same
// formula.
// ----------------------------------------------------------------------------
module rotary_position_pair_rotator
    import rppr_pkg::*;
#(
    parameter int HEAD_SIZE   = RPPR_HEAD_SIZE,
    parameter int FREQ_BASE   = RPPR_FREQ_BASE,
    parameter int QUEUE_DEPTH = RPPR_QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [POS_W-1:0]        position,
    input  logic [PAIR_W-1:0]       pair_index,
    input  logic signed [VAL_W-1:0] first_value,
    input  logic signed [VAL_W-1:0] second_value,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [VAL_W-1:0] first_rotated,
    output logic signed [VAL_W-1:0] second_rotated,
    output logic                    saturated
);

    rppr_qstat_t              qstat;
    logic                     push;
    rppr_word_t               push_word;
    logic                     pop;
    rppr_word_t               head_word;
    logic                     back_en;
    logic                     sc_valid;
    rppr_side_t               sc_side;
    logic signed [TRIG_W-1:0] sc_sin;
    logic signed [TRIG_W-1:0] sc_cos;

    // Back end holds only while a result waits on a stalled output
    assign back_en = !(result_valid && result_stall);
    assign pop     = back_en && !qstat.empty;

    rppr_front #(
        .HEAD_SIZE (HEAD_SIZE),
        .FREQ_BASE (FREQ_BASE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .position     (position),
        .pair_index   (pair_index),
        .first_value  (first_value),
        .second_value (second_value),
        .qstat        (qstat),
        .push         (push),
        .push_word    (push_word)
    );

    rppr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .pop   (pop),
        .rdata (head_word),
        .stat  (qstat)
    );

    rppr_sincos u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (pop),
        .in_word   (head_word),
        .out_valid (sc_valid),
        .out_side  (sc_side),
        .out_sin   (sc_sin),
        .out_cos   (sc_cos)
    );

    rppr_rotate u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (back_en),
        .in_valid       (sc_valid),
        .in_side        (sc_side),
        .in_sin         (sc_sin),
        .in_cos         (sc_cos),
        .result_valid   (result_valid),
        .first_rotated  (first_rotated),
        .second_rotated (second_rotated),
        .saturated      (saturated)
    );

endmodule
